// File: hdl/pidaw_pkg.sv
package pidaw_pkg;

  localparam int DataW = 32;
  localparam int SumW = 48;
  localparam int AccW = 82;
  localparam int DigitW = 4;

  typedef enum logic [2:0] {
    REG_KP        = 3'd0,
    REG_KI_DT     = 3'd1,
    REG_KD_F      = 3'd2,
    REG_KF        = 3'd3,
    REG_OUT_UPPER = 3'd4,
    REG_OUT_LOWER = 3'd5,
    REG_PWM_SCALE = 3'd6
  } reg_index_t;

  typedef enum logic {
    OP_RUN   = 1'b0,
    OP_CLEAR = 1'b1
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_AW_MUL,
    ST_AW_CHK,
    ST_P_MUL,
    ST_I_MUL,
    ST_D_MUL,
    ST_F_MUL,
    ST_ROUND,
    ST_PWM_GO,
    ST_PWM_MUL,
    ST_PWM_FIN,
    ST_OUT
  } state_t;

endpackage

// File: hdl/pidaw_mul.sv
module pidaw_mul (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     start,
  input  logic [pidaw_pkg::SumW-1:0]               a_mag,
  input  logic [pidaw_pkg::DataW-1:0]              b_mag,
  output logic                                     busy,
  output logic                                     done,
  output logic [pidaw_pkg::SumW+pidaw_pkg::DataW-1:0] product
);
  import pidaw_pkg::*;

  localparam int Steps = DataW / DigitW;
  localparam int CntW = $clog2(Steps + 1);
  localparam int PW = SumW + DataW;

  logic [DataW-1:0] b_sh;
  logic [PW-1:0] a_sh;
  logic [PW-1:0] acc;
  logic [CntW-1:0] cnt;
  logic [PW-1:0] part;

  always_comb begin
    part = a_sh * PW'(b_sh[DigitW-1:0]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= CntW'(Steps);
      end else if (cnt != '0) begin
        cnt <= cnt - CntW'(1);
        if (cnt == CntW'(1)) done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_sh <= PW'(a_mag);
      b_sh <= b_mag;
      acc <= '0;
    end else if (cnt != '0) begin
      acc <= acc + part;
      a_sh <= a_sh << DigitW;
      b_sh <= b_sh >> DigitW;
    end
  end

  assign busy = (cnt != '0);
  assign product = acc;

endmodule

// File: hdl/pid_antiwindup_feedforward_unit.sv
// pid controller with anti-windup and feed-forward, signed q16.16
// input channel: in_valid/in_stall with operation, reference, error_sample
// output channel: out_valid/out_stall with control_output, pwm_duty,
// windup_held; one result per item, in order
// config channel: cfg_valid/cfg_ready with cfg_index and cfg_data, always
// ready; write only while idle, indexes beyond the register list are ignored
// one item at a time; a run step makes six products on one shared
// multiplier that takes one 4-bit digit of the gain or scale per cycle;
// a clear step makes only the pwm product
// the result sits in an output register until taken; while out_stall is
// high it holds, the next item may still be taken and worked on but waits
// before the output register until the held result is taken
// reset (synchronous, rst high) clears registers, error sum, last error
// and last output to zero and drops out_valid
module pid_antiwindup_feedforward_unit (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               operation,
  input  logic signed [31:0]                 reference,
  input  logic signed [31:0]                 error_sample,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [31:0]                 control_output,
  output logic signed [10:0]                 pwm_duty,
  output logic                               windup_held,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [2:0]                         cfg_index,
  input  logic [31:0]                        cfg_data
);
  import pidaw_pkg::*;

  localparam int PW = SumW + DataW;

  logic signed [31:0] kp, ki_dt, kd_f, kf, out_upper, out_lower;
  logic [31:0] pwm_scale;
  logic signed [SumW-1:0] error_sum;
  logic signed [31:0] last_error, last_output;

  state_t state, state_next;
  logic signed [31:0] ref_r, e_r;
  logic signed [SumW-1:0] cand;
  logic signed [AccW-1:0] acc;
  logic held;
  logic signed [31:0] clamped;

  logic mul_start, mul_busy, mul_done;
  logic [SumW-1:0] ma;
  logic [DataW-1:0] mb;
  logic mneg;
  logic [PW-1:0] mprod;
  logic signed [AccW-1:0] sprod;

  logic signed [SumW:0] cand_w;
  logic signed [SumW-1:0] cand_sat;
  logic signed [32:0] diff;
  logic signed [AccW-1:0] hi_lim, lo_lim;
  logic signed [31:0] res;
  logic [31:0] counts;

  pidaw_mul u_mul (
    .clk(clk), .rst(rst), .start(mul_start), .a_mag(ma), .b_mag(mb),
    .busy(mul_busy), .done(mul_done), .product(mprod)
  );

  assign in_stall = (state != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign sprod = mneg ? -$signed({2'b00, mprod}) : $signed({2'b00, mprod});

  assign cand_w = (SumW+1)'(error_sum) + (SumW+1)'(error_sample);
  assign diff = 33'(e_r) - 33'(last_error);
  assign hi_lim = AccW'(out_upper) <<< 16;
  assign lo_lim = AccW'(out_lower) <<< 16;

  always_comb begin
    if (cand_w > (SumW+1)'(48'sh7fffffffffff)) cand_sat = 48'sh7fffffffffff;
    else if (cand_w < -(SumW+1)'(49'sh800000000000)) cand_sat = 48'sh800000000000;
    else cand_sat = cand_w[SumW-1:0];
  end

  always_comb begin
    if (acc >= (AccW'(1) <<< 47)) res = 32'sh7fffffff;
    else if (acc < -(AccW'(1) <<< 47)) res = 32'sh80000000;
    else res = acc[47:16];
  end

  always_comb begin
    counts = mprod[63:32];
  end

  // operand select for the shared multiplier
  always_comb begin
    ma = '0;
    mb = '0;
    unique case (state)
      ST_IDLE: begin
        ma = cand_sat[SumW-1] ? -cand_sat : cand_sat;
        mb = ki_dt[31] ? 32'(-ki_dt) : ki_dt;
      end
      ST_AW_CHK: begin
        ma = SumW'(e_r[31] ? -33'(e_r) : 33'(e_r));
        mb = kp[31] ? 32'(-kp) : kp;
      end
      ST_P_MUL: begin
        ma = error_sum[SumW-1] ? -error_sum : error_sum;
        mb = ki_dt[31] ? 32'(-ki_dt) : ki_dt;
      end
      ST_I_MUL: begin
        ma = SumW'(diff[32] ? -diff : diff);
        mb = kd_f[31] ? 32'(-kd_f) : kd_f;
      end
      ST_D_MUL: begin
        ma = SumW'(ref_r[31] ? -33'(ref_r) : 33'(ref_r));
        mb = kf[31] ? 32'(-kf) : kf;
      end
      ST_PWM_GO: begin
        ma = SumW'(clamped[31] ? -33'(clamped) : 33'(clamped));
        mb = pwm_scale;
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  always_comb begin
    state_next = state;
    mul_start = 1'b0;
    unique case (state)
      ST_IDLE: if (in_valid && !in_stall) begin
        state_next = (operation == OP_CLEAR) ? ST_PWM_GO : ST_AW_MUL;
        mul_start = (operation == OP_RUN);
      end
      ST_AW_MUL: if (mul_done) state_next = ST_AW_CHK;
      ST_AW_CHK: begin
        mul_start = 1'b1;
        state_next = ST_P_MUL;
      end
      ST_P_MUL: if (mul_done) begin
        mul_start = 1'b1;
        state_next = ST_I_MUL;
      end
      ST_I_MUL: if (mul_done) begin
        mul_start = 1'b1;
        state_next = ST_D_MUL;
      end
      ST_D_MUL: if (mul_done) begin
        mul_start = 1'b1;
        state_next = ST_F_MUL;
      end
      ST_F_MUL: if (mul_done) state_next = ST_ROUND;
      ST_ROUND: state_next = ST_PWM_GO;
      ST_PWM_GO: begin
        mul_start = 1'b1;
        state_next = ST_PWM_MUL;
      end
      ST_PWM_MUL: if (mul_done) state_next = ST_PWM_FIN;
      ST_PWM_FIN: if (!out_valid || !out_stall) state_next = ST_OUT;
      ST_OUT: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      kp <= '0; ki_dt <= '0; kd_f <= '0; kf <= '0;
      out_upper <= '0; out_lower <= '0; pwm_scale <= '0;
      error_sum <= '0; last_error <= '0; last_output <= '0;
      out_valid <= 1'b0;
      held <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_KP: kp <= cfg_data;
          REG_KI_DT: ki_dt <= cfg_data;
          REG_KD_F: kd_f <= cfg_data;
          REG_KF: kf <= cfg_data;
          REG_OUT_UPPER: out_upper <= cfg_data;
          REG_OUT_LOWER: out_lower <= cfg_data;
          REG_PWM_SCALE: pwm_scale <= cfg_data;
          default: ;
        endcase
      end
      if (out_valid && !out_stall) out_valid <= 1'b0;
      unique case (state)
        ST_IDLE: if (in_valid && !in_stall) begin
          held <= 1'b0;
          if (operation == OP_CLEAR) begin
            error_sum <= '0;
          end
        end
        ST_AW_MUL: if (mul_done) begin
          if (sprod > hi_lim || sprod < lo_lim) held <= 1'b1;
          else error_sum <= cand;
        end
        ST_ROUND: begin
          last_error <= e_r;
          last_output <= res;
        end
        ST_OUT: out_valid <= 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: if (in_valid && !in_stall) begin
        ref_r <= reference;
        e_r <= error_sample;
        mneg <= cand_sat[SumW-1] ^ ki_dt[31];
        acc <= AccW'(32'sh8000);
        cand <= cand_sat;
      end
      ST_AW_CHK: mneg <= e_r[31] ^ kp[31];
      ST_P_MUL: if (mul_done) begin
        acc <= acc + sprod;
        mneg <= error_sum[SumW-1] ^ ki_dt[31];
      end
      ST_I_MUL: if (mul_done) begin
        acc <= acc + sprod;
        mneg <= diff[32] ^ kd_f[31];
      end
      ST_D_MUL: if (mul_done) begin
        acc <= acc + sprod;
        mneg <= ref_r[31] ^ kf[31];
      end
      ST_F_MUL: if (mul_done) acc <= acc + sprod;
      ST_PWM_GO: begin
        mneg <= clamped[31];
      end
      ST_PWM_FIN: if (!out_valid || !out_stall) begin
        control_output <= last_output;
        windup_held <= held;
        if (counts > 32'd1023) pwm_duty <= mneg ? -11'sd1023 : 11'sd1023;
        else pwm_duty <= mneg ? -$signed(counts[10:0]) : $signed(counts[10:0]);
      end
      default: ;
    endcase
  end

  // clamp of the current last output for the duty product
  always_comb begin
    if (last_output > out_upper) clamped = out_upper;
    else if (last_output < out_lower) clamped = out_lower;
    else clamped = last_output;
  end

  a_busy_idle: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !mul_busy)
    else $error("multiplier busy while idle");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(control_output)
      && $stable(pwm_duty) && $stable(windup_held)))
    else $error("result changed while stalled");
  a_duty_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (pwm_duty != 11'h400))
    else $error("duty out of range");

endmodule

// File: bench/pid_antiwindup_feedforward_unit_checker.sv
module pid_antiwindup_feedforward_unit_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic               operation,
  input  logic signed [31:0] reference,
  input  logic signed [31:0] error_sample,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic signed [31:0] control_output,
  input  logic signed [10:0] pwm_duty,
  input  logic               windup_held,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  output int                 mismatches,
  output int                 outstanding
);
  timeunit 1ns;
  timeprecision 1ps;
  import pidaw_pkg::*;

  typedef struct {
    logic signed [31:0] y;
    logic signed [10:0] duty;
    logic               held;
  } ctl_result_t;

  localparam logic signed [127:0] SumHi = 128'sh7FFF_FFFF_FFFF;
  localparam logic signed [127:0] SumLo = -128'sh8000_0000_0000;

  logic signed [31:0] kp, ki_dt, kd_f, kf, upper, lower;
  logic [31:0]        scale;
  logic signed [47:0] integ;
  logic signed [31:0] prev_err, prev_y;
  ctl_result_t        pending_results[$];

  assign outstanding = pending_results.size();

  function automatic logic signed [10:0] duty_of(logic signed [31:0] y);
    logic signed [31:0] c;
    logic [31:0]        m;
    logic [63:0]        p;
    logic [10:0]        n;
    c = y;
    if (c > upper) c = upper;
    else if (c < lower) c = lower;
    m = c[31] ? 32'(-c) : 32'(c);
    p = 64'(m) * 64'(scale);
    n = (p[63:32] > 32'd1023) ? 11'd1023 : p[42:32];
    return c[31] ? -$signed(n) : $signed(n);
  endfunction

  function automatic ctl_result_t control_step(logic op, logic signed [31:0] r,
                                               logic signed [31:0] e);
    ctl_result_t        res;
    logic signed [127:0] cand, prod, acc, e_w, r_w, d_w;
    logic signed [127:0] hi_w, lo_w, ki_w;
    if (op == OP_CLEAR) begin
      integ = '0;
      res.y = prev_y;
      res.duty = duty_of(prev_y);
      res.held = 1'b0;
      return res;
    end
    e_w = e;
    r_w = r;
    ki_w = ki_dt;
    cand = 128'(integ) + e_w;
    if (cand > SumHi) cand = SumHi;
    if (cand < SumLo) cand = SumLo;
    prod = cand * ki_w;
    hi_w = 128'(upper) <<< 16;
    lo_w = 128'(lower) <<< 16;
    res.held = (prod > hi_w) || (prod < lo_w);
    if (!res.held) integ = cand[47:0];
    d_w = e_w - 128'(prev_err);
    acc = e_w * 128'(kp) + 128'(integ) * ki_w + d_w * 128'(kd_f) + r_w * 128'(kf)
          + 128'sh8000;
    if (acc >= (128'sd1 <<< 47)) res.y = 32'sh7FFF_FFFF;
    else if (acc < -(128'sd1 <<< 47)) res.y = 32'sh8000_0000;
    else res.y = acc[47:16];
    prev_err = e;
    prev_y = res.y;
    res.duty = duty_of(res.y);
    return res;
  endfunction

  always @(posedge clk) begin
    ctl_result_t want;
    if (rst) begin
      kp = 0; ki_dt = 0; kd_f = 0; kf = 0; upper = 0; lower = 0; scale = 0;
      integ = 0; prev_err = 0; prev_y = 0;
      pending_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (reg_index_t'(cfg_index))
          REG_KP:        kp = cfg_data;
          REG_KI_DT:     ki_dt = cfg_data;
          REG_KD_F:      kd_f = cfg_data;
          REG_KF:        kf = cfg_data;
          REG_OUT_UPPER: upper = cfg_data;
          REG_OUT_LOWER: lower = cfg_data;
          REG_PWM_SCALE: scale = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall)
        pending_results.push_back(control_step(operation, reference, error_sample));
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          mismatches++;
          $display("%0t: result with none expected: y=%h duty=%0d held=%b", $time,
                   control_output, pwm_duty, windup_held);
        end else begin
          want = pending_results.pop_front();
          if (control_output !== want.y) begin
            mismatches++;
            $display("%0t: control_output expected %h actual %h", $time, want.y,
                     control_output);
          end
          if (pwm_duty !== want.duty) begin
            mismatches++;
            $display("%0t: pwm_duty expected %0d actual %0d", $time, want.duty, pwm_duty);
          end
          if (windup_held !== want.held) begin
            mismatches++;
            $display("%0t: windup_held expected %b actual %b", $time, want.held,
                     windup_held);
          end
        end
      end
    end
  end

  initial mismatches = 0;
endmodule

// File: bench/pid_antiwindup_feedforward_unit_test.sv
module pid_antiwindup_feedforward_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import pidaw_pkg::*;

  localparam int CycleLimit = 1000000;

  logic               clk = 0;
  logic               rst = 1;
  logic               in_valid = 0;
  logic               in_stall;
  logic               operation = OP_RUN;
  logic signed [31:0] reference = 0;
  logic signed [31:0] error_sample = 0;
  logic               out_valid;
  logic               out_stall = 0;
  logic signed [31:0] control_output;
  logic signed [10:0] pwm_duty;
  logic               windup_held;
  logic               cfg_valid = 0;
  logic               cfg_ready;
  logic [2:0]         cfg_index = 0;
  logic [31:0]        cfg_data = 0;
  int                 mismatches, outstanding;
  int                 cycles = 0;
  logic               no_idle = 0;

  pid_antiwindup_feedforward_unit dut (.*);
  pid_antiwindup_feedforward_unit_checker checker_i (.*);

  initial forever #6 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    out_stall <= !no_idle && ($urandom_range(99) < 29);
    if (cycles > CycleLimit) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic write_reg(reg_index_t idx, logic [31:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
  endtask

  task automatic drain();
    while (outstanding != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic send_item(op_t op, logic [31:0] r, logic [31:0] e);
    if (!no_idle && $urandom_range(99) < 29) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1;
    operation <= op;
    reference <= r;
    error_sample <= e;
    do @(posedge clk); while (in_stall);
  endtask

  function automatic logic [31:0] gain_word();
    case ($urandom_range(7))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0;
      3: return $urandom;
      default: return $urandom_range(1, 32'h3_0000) * ($urandom_range(1) ? 1 : -1);
    endcase
  endfunction

  function automatic logic [31:0] err_word();
    case ($urandom_range(9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2, 3: return $urandom;
      default: return $urandom_range(0, 32'h8_0000) - 32'h4_0000;
    endcase
  endfunction

  task automatic write_all(logic [31:0] g0, g1, g2, g3, hi, lo, sc);
    write_reg(REG_KP, g0);
    write_reg(REG_KI_DT, g1);
    write_reg(REG_KD_F, g2);
    write_reg(REG_KF, g3);
    write_reg(REG_OUT_UPPER, hi);
    write_reg(REG_OUT_LOWER, lo);
    write_reg(REG_PWM_SCALE, sc);
  endtask

  initial begin
    logic [31:0] hi, lo;
    repeat (6) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed
    write_all(32'h1_0000, 32'h1000, 32'h800, 32'h8000, 32'd100 << 16,
              -(32'd100 << 16), 32'd670433);
    send_item(OP_RUN, 32'h1_0000, 32'h2_0000);
    send_item(OP_RUN, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_item(OP_RUN, 32'h8000_0000, 32'h8000_0000);
    send_item(OP_RUN, 32'h0, 32'h7FFF_FFFF);
    send_item(OP_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(OP_RUN, 32'h0, -32'h5_0000);
    send_item(OP_CLEAR, 32'h0, 32'h0);
    in_valid <= 0;
    drain();
    write_all(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
              32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
    send_item(OP_RUN, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_item(OP_RUN, 32'h8000_0000, 32'h8000_0000);
    send_item(OP_RUN, 32'h1234_5678, 32'h1);
    send_item(OP_CLEAR, 32'h0, 32'h0);
    in_valid <= 0;
    drain();
    // crossed limits, zero scale
    write_all(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
              -(32'd5 << 16), 32'd5 << 16, 32'h0);
    send_item(OP_RUN, 32'h1_0000, 32'h1_0000);
    send_item(OP_RUN, 32'h0, -32'h1_0000);
    send_item(OP_RUN, 32'h7FFF_FFFF, 32'h0);
    send_item(OP_CLEAR, 32'h0, 32'h0);
    in_valid <= 0;
    drain();
    write_reg(REG_PWM_SCALE, 32'h0800_0000);
    send_item(OP_RUN, 32'h8000_0000, 32'h7FFF_FFFF);
    in_valid <= 0;
    drain();

    // random
    for (int ph = 0; ph < 6; ph++) begin
      hi = $urandom_range(1, 32'h200_0000);
      lo = -$urandom_range(1, 32'h200_0000);
      if (ph == 3) {hi, lo} = {lo, hi};
      if (ph == 5) begin
        hi = 32'h7FFF_FFFF;
        lo = 32'h8000_0000;
      end
      write_all(gain_word(), ($urandom_range(3) == 0) ? gain_word() : $urandom_range(0, 32'h4000),
                gain_word(), gain_word(), hi, lo,
                ($urandom_range(5) == 0) ? $urandom : $urandom_range(0, 32'h200_0000));
      no_idle <= (ph == 2);
      for (int n = 0; n < 300; n++) begin
        if (n == 150 && ph == 1) begin
          in_valid <= 0;
          while (outstanding != 0) @(posedge clk);
        end
        send_item(($urandom_range(15) == 0) ? OP_CLEAR : OP_RUN,
                  ($urandom_range(3) == 0) ? $urandom : err_word(), err_word());
      end
      in_valid <= 0;
      no_idle <= 0;
      drain();
    end

    if (mismatches == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end
endmodule
